[hdl/ttdp_pkg.sv]
package ttdp_pkg;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_SUM,
        ST_ITER,
        ST_ROUND,
        ST_TURN,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_DIV,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic busy;
        logic capture;
        logic prep;
        logic sum;
        logic iter;
        logic round;
        logic turn;
        logic mul1;
        logic mul2;
        logic mul3;
        logic div;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic iter_last;
        logic out_free;
    } sts_t;

    // Register indexes.
    localparam logic REG_MAX_SPEED    = 1'b0;
    localparam logic REG_WHEEL_RADIUS = 1'b1;

    localparam logic [7:0]  MAX_SPEED_RESET    = 8'd255;
    localparam logic [11:0] WHEEL_RADIUS_RESET = 12'd300;

    // Fixed datapath widths.
    localparam int DLW = 17;  // coordinate delta
    localparam int XW  = 50;  // CORDIC x and y, delta scaled by 2^30
    localparam int ZW  = 26;  // CORDIC angle, degrees Q16
    localparam int SQW = 35;  // square root remainder, root and bit
    localparam int ISQRT_STEPS = 17;

    localparam logic signed [ZW-1:0] Z_90  = 26'sd5898240;
    localparam logic signed [ZW-1:0] Z_180 = 26'sd11796480;

    localparam logic [25:0] PI_Q24    = 26'd52707179;
    // ceil(2^26 / 45), exact for dividends below 2^20.
    localparam logic [20:0] RECIP_45  = 21'd1491309;
    localparam int          RECIP_SHIFT = 26;

    localparam logic [31:0] RAD2DEG_Q16 = 32'd3754936;

    // Arctangent of 2^-i in degrees Q16.
    function automatic logic [22:0] step_angle(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'd2949120;
            5'd1:    v = 32'd1740967;
            5'd2:    v = 32'd919879;
            5'd3:    v = 32'd466945;
            5'd4:    v = 32'd234379;
            5'd5:    v = 32'd117304;
            5'd6:    v = 32'd58666;
            5'd7:    v = 32'd29335;
            5'd8:    v = 32'd14668;
            5'd9:    v = 32'd7334;
            5'd10:   v = 32'd3667;
            5'd11:   v = 32'd1833;
            default: v = (RAD2DEG_Q16 + (32'd1 << (i - 5'd1))) >> i;
        endcase
        return v[22:0];
    endfunction

endpackage

[hdl/ttdp_ctrl.sv]
module ttdp_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  ttdp_pkg::sts_t  sts,
    output ttdp_pkg::cmd_t  cmd
);

    ttdp_pkg::state_t state_reg;
    ttdp_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ttdp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ttdp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ttdp_pkg::ST_PREP;
                end
            end
            ttdp_pkg::ST_PREP:  state_next = ttdp_pkg::ST_SUM;
            ttdp_pkg::ST_SUM:   state_next = ttdp_pkg::ST_ITER;
            ttdp_pkg::ST_ITER:
            begin
                if (sts.iter_last)
                begin
                    state_next = ttdp_pkg::ST_ROUND;
                end
            end
            ttdp_pkg::ST_ROUND: state_next = ttdp_pkg::ST_TURN;
            ttdp_pkg::ST_TURN:  state_next = ttdp_pkg::ST_MUL1;
            ttdp_pkg::ST_MUL1:  state_next = ttdp_pkg::ST_MUL2;
            ttdp_pkg::ST_MUL2:  state_next = ttdp_pkg::ST_MUL3;
            ttdp_pkg::ST_MUL3:  state_next = ttdp_pkg::ST_DIV;
            ttdp_pkg::ST_DIV:   state_next = ttdp_pkg::ST_OUT;
            ttdp_pkg::ST_OUT:
            begin
                if (sts.out_free)
                begin
                    state_next = ttdp_pkg::ST_IDLE;
                end
            end
            default:            state_next = ttdp_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.busy = (state_reg != ttdp_pkg::ST_IDLE);
        case (state_reg)
            ttdp_pkg::ST_IDLE:  cmd.capture = in_valid;
            ttdp_pkg::ST_PREP:  cmd.prep = 1'b1;
            ttdp_pkg::ST_SUM:   cmd.sum = 1'b1;
            ttdp_pkg::ST_ITER:  cmd.iter = 1'b1;
            ttdp_pkg::ST_ROUND: cmd.round = 1'b1;
            ttdp_pkg::ST_TURN:  cmd.turn = 1'b1;
            ttdp_pkg::ST_MUL1:  cmd.mul1 = 1'b1;
            ttdp_pkg::ST_MUL2:  cmd.mul2 = 1'b1;
            ttdp_pkg::ST_MUL3:  cmd.mul3 = 1'b1;
            ttdp_pkg::ST_DIV:   cmd.div = 1'b1;
            ttdp_pkg::ST_OUT:   cmd.load_out = sts.out_free;
            default:            cmd.busy = 1'b0;
        endcase
    end

endmodule

[hdl/ttdp_datapath.sv]
module ttdp_datapath
#(
    parameter int ANGLE_FRAC_BITS = 8,
    parameter int CORDIC_STEPS    = 18
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ttdp_pkg::cmd_t      cmd,
    output ttdp_pkg::sts_t      sts,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [11:0]         cfg_data,
    input  logic signed [15:0]  cur_x,
    input  logic signed [15:0]  cur_y,
    input  logic signed [15:0]  target_x,
    input  logic signed [15:0]  target_y,
    output logic signed [8:0]   heading_deg,
    output logic signed [8:0]   wheel_speed,
    output logic [13:0]         arc_length,
    output logic [16:0]         distance,
    output logic                no_turn,
    output logic                no_move,
    output logic                out_valid,
    input  logic                out_stall
);

    localparam int F    = ANGLE_FRAC_BITS;
    localparam int AW   = F + 9;
    localparam int DW   = F + 11;
    localparam int TW   = F + 8;
    localparam int P1W  = F + 20;
    localparam int LOW  = P1W / 2;
    localparam int HIGH = P1W - LOW;
    localparam int PW   = F + 46;
    localparam int S    = 16 - F;
    localparam int RND  = (S > 0) ? (1 << (S - 1)) : 0;
    localparam int MAXI = (CORDIC_STEPS > ttdp_pkg::ISQRT_STEPS) ?
                          CORDIC_STEPS : ttdp_pkg::ISQRT_STEPS;
    localparam int CW   = $clog2(MAXI + 1);
    localparam int XW   = ttdp_pkg::XW;
    localparam int ZW   = ttdp_pkg::ZW;
    localparam int SQW  = ttdp_pkg::SQW;
    localparam int DLW  = ttdp_pkg::DLW;

    localparam logic [TW-1:0]        LIM  = TW'(180 << F);
    localparam logic signed [DW-1:0] FULL = DW'(360 << F);

    // Configuration and heading.
    logic [7:0]                max_speed_reg;
    logic [11:0]               wheel_radius_reg;
    logic signed [AW-1:0]      heading_reg;
    logic signed [AW-1:0]      heading_next;

    // Work registers.
    logic signed [DLW-1:0]     dx_reg, dx_next;
    logic signed [DLW-1:0]     dy_reg, dy_next;
    logic signed [XW-1:0]      x_reg, x_next;
    logic signed [XW-1:0]      y_reg, y_next;
    logic signed [ZW-1:0]      z_reg, z_next;
    logic                      axis_reg, axis_next;
    logic signed [ZW-1:0]      zaxis_reg, zaxis_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [2*DLW-1:0]          sqx_reg, sqx_next;
    logic [2*DLW-1:0]          sqy_reg, sqy_next;
    logic [SQW-1:0]            rem_reg, rem_next;
    logic [SQW-1:0]            root_reg, root_next;
    logic [SQW-1:0]            bit_reg, bit_next;
    logic signed [AW-1:0]      alpha_reg, alpha_next;
    logic [TW-1:0]             turn_reg, turn_next;
    logic                      pos_reg, pos_next;
    logic [P1W-1:0]            p1_reg, p1_next;
    logic [HIGH+25:0]          hi_reg, hi_next;
    logic [PW-1:0]             prod_reg, prod_next;
    logic [13:0]               arc_reg, arc_next;

    // Output register.
    logic                      out_valid_reg;
    logic signed [8:0]         deg_reg;
    logic signed [8:0]         speed_reg;
    logic [13:0]               arc_out_reg;
    logic [16:0]               dist_reg;

    // Combinational temporaries.
    logic signed [2*DLW-1:0]   sq_x, sq_y;
    logic signed [XW-1:0]      x_sh, y_sh;
    logic signed [ZW-1:0]      ang;
    logic [SQW-1:0]            trial;
    logic signed [ZW-1:0]      z_fin;
    logic [ZW-1:0]             z_mag, z_rnd;
    logic [TW-1:0]             a_mag;
    logic signed [DW-1:0]      cur_w, alpha_w, diff_a, diff_b;
    logic [PW-1:0]             lo_prod;
    logic [40:0]               quot;
    logic [AW-1:0]             deg_mag;
    logic [AW-1:0]             deg_shift;

    always_comb
    begin
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;
        axis_next    = axis_reg;
        zaxis_next   = zaxis_reg;
        cnt_next     = cnt_reg;
        sqx_next     = sqx_reg;
        sqy_next     = sqy_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        bit_next     = bit_reg;
        alpha_next   = alpha_reg;
        turn_next    = turn_reg;
        pos_next     = pos_reg;
        p1_next      = p1_reg;
        hi_next      = hi_reg;
        prod_next    = prod_reg;
        arc_next     = arc_reg;
        heading_next = heading_reg;

        sq_x      = dx_reg * dx_reg;
        sq_y      = dy_reg * dy_reg;
        x_sh      = x_reg >>> cnt_reg;
        y_sh      = y_reg >>> cnt_reg;
        ang       = ZW'(ttdp_pkg::step_angle(cnt_reg[4:0]));
        trial     = root_reg + bit_reg;
        z_fin     = axis_reg ? zaxis_reg : z_reg;
        z_mag     = z_fin[ZW-1] ? ZW'(-z_fin) : ZW'(z_fin);
        z_rnd     = (z_mag + ZW'(RND)) >> S;
        a_mag     = (z_rnd > ZW'(LIM)) ? LIM : TW'(z_rnd);
        cur_w     = DW'(heading_reg);
        alpha_w   = DW'(alpha_reg);
        diff_a    = (cur_w > alpha_w) ? (cur_w - alpha_w) : (alpha_w - cur_w);
        diff_b    = FULL - diff_a;
        lo_prod   = PW'(p1_reg[LOW-1:0]) * PW'(ttdp_pkg::PI_Q24);
        quot      = prod_reg[PW-1:F+26] * ttdp_pkg::RECIP_45;

        if (cmd.capture)
        begin
            dx_next = DLW'(target_x) - DLW'(cur_x);
            dy_next = DLW'(target_y) - DLW'(cur_y);
        end

        if (cmd.prep)
        begin
            sqx_next  = $unsigned(sq_x);
            sqy_next  = $unsigned(sq_y);
            cnt_next  = '0;
            root_next = '0;
            bit_next  = SQW'(1) << 32;
            axis_next = (dx_reg == '0) || (dy_reg == '0);
            if (dy_reg == '0)
            begin
                zaxis_next = (dx_reg < 0) ? ttdp_pkg::Z_180 : '0;
            end
            else
            begin
                zaxis_next = (dy_reg > 0) ? ttdp_pkg::Z_90 : -ttdp_pkg::Z_90;
            end
            // Points left of the y axis are first turned by a quarter turn.
            if (dx_reg < 0)
            begin
                if (dy_reg >= 0)
                begin
                    x_next = XW'(dy_reg) <<< 30;
                    y_next = XW'(-dx_reg) <<< 30;
                    z_next = ttdp_pkg::Z_90;
                end
                else
                begin
                    x_next = XW'(-dy_reg) <<< 30;
                    y_next = XW'(dx_reg) <<< 30;
                    z_next = -ttdp_pkg::Z_90;
                end
            end
            else
            begin
                x_next = XW'(dx_reg) <<< 30;
                y_next = XW'(dy_reg) <<< 30;
                z_next = '0;
            end
        end

        if (cmd.sum)
        begin
            rem_next = SQW'(sqx_reg) + SQW'(sqy_reg);
        end

        if (cmd.iter)
        begin
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg < CW'(CORDIC_STEPS))
            begin
                if (y_reg > 0)
                begin
                    x_next = x_reg + y_sh;
                    y_next = y_reg - x_sh;
                    z_next = z_reg + ang;
                end
                else
                begin
                    x_next = x_reg - y_sh;
                    y_next = y_reg + x_sh;
                    z_next = z_reg - ang;
                end
            end
            if (cnt_reg < CW'(ttdp_pkg::ISQRT_STEPS))
            begin
                if (rem_reg >= trial)
                begin
                    rem_next  = rem_reg - trial;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
            end
        end

        if (cmd.round)
        begin
            alpha_next = z_fin[ZW-1] ? -AW'(a_mag) : AW'(a_mag);
        end

        if (cmd.turn)
        begin
            turn_next    = (diff_a > diff_b) ? TW'(diff_b) : TW'(diff_a);
            pos_next     = !(cur_w > alpha_w) && !(diff_a > diff_b);
            heading_next = alpha_reg;
        end

        if (cmd.mul1)
        begin
            p1_next = P1W'(wheel_radius_reg) * P1W'(turn_reg);
        end

        if (cmd.mul2)
        begin
            hi_next = p1_reg[P1W-1:LOW] * ttdp_pkg::PI_Q24;
        end

        if (cmd.mul3)
        begin
            prod_next = {hi_reg, {LOW{1'b0}}} + lo_prod;
        end

        if (cmd.div)
        begin
            arc_next = quot[ttdp_pkg::RECIP_SHIFT+13:ttdp_pkg::RECIP_SHIFT];
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        axis_reg  <= axis_next;
        zaxis_reg <= zaxis_next;
        sqx_reg   <= sqx_next;
        sqy_reg   <= sqy_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        bit_reg   <= bit_next;
        alpha_reg <= alpha_next;
        turn_reg  <= turn_next;
        pos_reg   <= pos_next;
        p1_reg    <= p1_next;
        hi_reg    <= hi_next;
        prod_reg  <= prod_next;
        arc_reg   <= arc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg          <= '0;
            heading_reg      <= '0;
            max_speed_reg    <= ttdp_pkg::MAX_SPEED_RESET;
            wheel_radius_reg <= ttdp_pkg::WHEEL_RADIUS_RESET;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            heading_reg <= heading_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    ttdp_pkg::REG_MAX_SPEED:    max_speed_reg    <= cfg_data[7:0];
                    ttdp_pkg::REG_WHEEL_RADIUS: wheel_radius_reg <= cfg_data;
                    default:                    max_speed_reg    <= max_speed_reg;
                endcase
            end
        end
    end

    // Whole degrees, truncated toward zero.
    assign deg_mag   = alpha_reg[AW-1] ? AW'(-alpha_reg) : AW'(alpha_reg);
    assign deg_shift = deg_mag >> F;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            deg_reg     <= alpha_reg[AW-1] ? -9'(deg_shift) : 9'(deg_shift);
            speed_reg   <= pos_reg ? -9'(max_speed_reg) : 9'(max_speed_reg);
            arc_out_reg <= arc_reg;
            dist_reg    <= root_reg[16:0];
        end
    end

    assign sts.iter_last = (cnt_reg == CW'(MAXI - 1));
    assign sts.out_free  = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign heading_deg = deg_reg;
    assign wheel_speed = speed_reg;
    assign arc_length  = arc_out_reg;
    assign distance    = dist_reg;
    assign no_turn     = (arc_out_reg == '0);
    assign no_move     = (dist_reg == '0);

endmodule

[hdl/turn_then_drive_planner.sv]
// Turn-then-drive planner. Each transaction on the input channel carries a
// current and a target point; the block answers with one result transaction
// holding the new course angle in whole degrees, the signed wheel speed (wheel
// two takes the negated value), the turn arc length, the straight distance and
// two flags for no turn and no move. After acceptance the block squares the
// deltas and sets up CORDIC, sums the squares, runs one step per cycle of the
// iterative CORDIC unit (the 17 square-root steps run alongside), then does
// rounding, turn selection, the arc multiply in states MUL1, MUL2 and MUL3,
// the reciprocal divide by 180 and the output load, which waits while a
// stalled result still holds the output register. The next item is taken in
// the cycle after the result is loaded. One item is in work at a time; a
// finished result sits in an output register, so the next item is accepted
// while the previous result still waits to be taken.
module turn_then_drive_planner
#(
    parameter int ANGLE_FRAC_BITS = 8,
    parameter int CORDIC_STEPS    = 18
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [11:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [15:0]  cur_x,
    input  logic signed [15:0]  cur_y,
    input  logic signed [15:0]  target_x,
    input  logic signed [15:0]  target_y,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [8:0]   heading_deg,
    output logic signed [8:0]   wheel_speed,
    output logic [13:0]         arc_length,
    output logic [16:0]         distance,
    output logic                no_turn,
    output logic                no_move
);

    ttdp_pkg::cmd_t cmd;
    ttdp_pkg::sts_t sts;

    // The controller sequences capture, CORDIC and square-root iteration,
    // rounding, turn selection, the arc multiply and the output load.
    ttdp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the configuration registers, the stored heading and
    // all arithmetic, plus the output register.
    ttdp_datapath
    #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STEPS    (CORDIC_STEPS)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cur_x       (cur_x),
        .cur_y       (cur_y),
        .target_x    (target_x),
        .target_y    (target_y),
        .heading_deg (heading_deg),
        .wheel_speed (wheel_speed),
        .arc_length  (arc_length),
        .distance    (distance),
        .no_turn     (no_turn),
        .no_move     (no_move),
        .out_valid   (out_valid),
        .out_stall   (out_stall)
    );

    // The input side is held off while an item is in work.
    assign in_stall = cmd.busy;

    // An accepted transaction always starts work that holds off the next one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted without starting work");

    // A new result only appears at the end of work on an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without an item in work");

    // The reported course stays within a half turn either way.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (heading_deg <= 9'sd180 && heading_deg >= -9'sd180))
        else $error("heading out of range");

endmodule
